// ----- sv/char_lcd_nibble_sequencer_core_assert.svh -----
// Assertion macros for the character LCD nibble sequencer.
// Expects signals named clk and rst_n in the including module.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LCDSEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCDSEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lcdseq_pkg.sv -----
// Package for the character LCD nibble sequencer: request kinds, timing constants
// and the pin step record. No dependencies.
package lcdseq_pkg;

  localparam int KindW  = 2;
  localparam int ValueW = 8;
  localparam int NibW   = 4;
  localparam int HoldW  = 10;
  localparam int StepW  = 4;

  localparam logic [KindW-1:0] KIND_INIT = 2'd0;
  localparam logic [KindW-1:0] KIND_CMD  = 2'd1;
  localparam logic [KindW-1:0] KIND_DATA = 2'd2;
  localparam logic [KindW-1:0] KIND_NONE = 2'd3;

  localparam logic [StepW-1:0] INIT_LAST_STEP = 4'd8;
  localparam logic [StepW-1:0] BYTE_LAST_STEP = 4'd3;

  localparam logic [HoldW-1:0] HOLD_STROBE  = 10'd1;
  localparam logic [HoldW-1:0] HOLD_POWERUP = 10'd750;
  localparam logic [HoldW-1:0] HOLD_INIT_1  = 10'd250;
  localparam logic [HoldW-1:0] HOLD_INIT_2  = 10'd5;
  localparam logic [HoldW-1:0] HOLD_SETTLE  = 10'd3;
  localparam logic [HoldW-1:0] HOLD_LONG    = 10'd113;

  localparam logic [NibW-1:0] NIB_INIT_8BIT = 4'h3;
  localparam logic [NibW-1:0] NIB_INIT_4BIT = 4'h2;

  localparam logic [ValueW-1:0] CMD_CLEAR = 8'h01;
  localparam logic [ValueW-2:0] CMD_HOME  = 7'h01;

  typedef struct packed {
    logic             reg_select;
    logic             enable;
    logic [NibW-1:0]  nibble;
    logic [HoldW-1:0] hold_units;
    logic             last;
  } step_t;

endpackage

// ----- sv/lcdseq_step_gen.sv -----
// Pin step decoder: maps a request and a step number to one bus pin state.
// Depends on lcdseq_pkg.
module lcdseq_step_gen (
  input  logic [lcdseq_pkg::KindW-1:0]  kind,
  input  logic [lcdseq_pkg::ValueW-1:0] value,
  input  logic [lcdseq_pkg::StepW-1:0]  step,
  output lcdseq_pkg::step_t             step_out
);

  logic                         long_cmd;
  logic [lcdseq_pkg::NibW-1:0]  byte_nib;
  logic [lcdseq_pkg::HoldW-1:0] fin_hold;

  assign long_cmd = (kind == lcdseq_pkg::KIND_CMD) &&
                    ((value == lcdseq_pkg::CMD_CLEAR) ||
                     (value[lcdseq_pkg::ValueW-1:1] == lcdseq_pkg::CMD_HOME));
  assign fin_hold = long_cmd ? lcdseq_pkg::HOLD_LONG : lcdseq_pkg::HOLD_SETTLE;
  assign byte_nib = step[1] ? value[3:0] : value[7:4];

  always_comb begin
    step_out = '0;
    unique case (kind) inside
      lcdseq_pkg::KIND_INIT: begin
        step_out.enable = step[0];
        step_out.nibble = (step >= 4'd7) ? lcdseq_pkg::NIB_INIT_4BIT
                                         : lcdseq_pkg::NIB_INIT_8BIT;
        step_out.last   = (step == lcdseq_pkg::INIT_LAST_STEP);
        unique case (step)
          4'd0: begin
            step_out.nibble     = '0;
            step_out.hold_units = lcdseq_pkg::HOLD_POWERUP;
          end
          4'd2:    step_out.hold_units = lcdseq_pkg::HOLD_INIT_1;
          4'd4:    step_out.hold_units = lcdseq_pkg::HOLD_INIT_2;
          4'd6:    step_out.hold_units = lcdseq_pkg::HOLD_SETTLE;
          4'd8:    step_out.hold_units = lcdseq_pkg::HOLD_SETTLE;
          default: step_out.hold_units = lcdseq_pkg::HOLD_STROBE;
        endcase
      end
      lcdseq_pkg::KIND_CMD, lcdseq_pkg::KIND_DATA: begin
        step_out.reg_select = (kind == lcdseq_pkg::KIND_DATA);
        step_out.enable     = ~step[0];
        step_out.nibble     = byte_nib;
        step_out.last       = (step == lcdseq_pkg::BYTE_LAST_STEP);
        step_out.hold_units = step_out.last ? fin_hold : lcdseq_pkg::HOLD_STROBE;
      end
      default: step_out = '0;
    endcase
  end

endmodule

// ----- sv/char_lcd_nibble_sequencer_core.sv -----
// Character LCD nibble sequencer: one request in, up to nine timed pin steps out.
// Requests pass the request, then the output registers; one step leaves per cycle
// while out_tready is high. Byte requests have four steps, init nine, by the step counter.
// The next request is taken in the cycle its predecessor's final step is registered.
// Reset (rst_n low, synchronous) empties the request and output registers.
// Depends on lcdseq_pkg, lcdseq_step_gen and char_lcd_nibble_sequencer_core_assert.svh.
`include "char_lcd_nibble_sequencer_core_assert.svh"

module char_lcd_nibble_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // value[7:0]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // reg_select[0], enable[1], nibble[5:2], hold_units[15:6]
  output logic        out_tlast
);

  logic                          item_valid_r, item_valid_nxt;
  logic [lcdseq_pkg::KindW-1:0]  kind_r, kind_nxt;
  logic [lcdseq_pkg::ValueW-1:0] value_r, value_nxt;
  logic [lcdseq_pkg::StepW-1:0]  step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;
  lcdseq_pkg::step_t             out_step_r, out_step_nxt;
  lcdseq_pkg::step_t             cur_step;
  logic                          out_load;
  logic                          in_acc;

  lcdseq_step_gen u_step_gen (
    .kind     (kind_r),
    .value    (value_r),
    .step     (step_r),
    .step_out (cur_step)
  );

  assign out_load  = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || (out_load && cur_step.last);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    item_valid_nxt = item_valid_r;
    kind_nxt       = kind_r;
    value_nxt      = value_r;
    step_nxt       = step_r;
    if (in_acc) begin
      item_valid_nxt = (in_tuser != lcdseq_pkg::KIND_NONE);
      kind_nxt       = in_tuser;
      value_nxt      = in_tdata;
      step_nxt       = '0;
    end else if (out_load) begin
      step_nxt = step_r + 4'd1;
      if (cur_step.last) begin
        item_valid_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_step_nxt  = out_step_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_step_nxt  = cur_step;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      step_r       <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      step_r       <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    value_r    <= value_nxt;
    out_step_r <= out_step_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_step_r.last;
  assign out_tdata  = {out_step_r.hold_units, out_step_r.nibble,
                       out_step_r.enable, out_step_r.reg_select};

  `LCDSEQ_ASSERT_NOW(a_no_unused_kind, item_valid_r, kind_r != lcdseq_pkg::KIND_NONE, "unused request kind held as live")
  `LCDSEQ_ASSERT_NOW(a_init_step_range, item_valid_r && kind_r == lcdseq_pkg::KIND_INIT, step_r <= lcdseq_pkg::INIT_LAST_STEP, "init step counter overran")
  `LCDSEQ_ASSERT_NOW(a_byte_step_range, item_valid_r && kind_r != lcdseq_pkg::KIND_INIT, step_r <= lcdseq_pkg::BYTE_LAST_STEP, "byte step counter overran")
  `LCDSEQ_ASSERT_NEXT(a_last_frees_slot, out_load && cur_step.last && !in_acc, !item_valid_r, "request slot not freed after final step")

endmodule
